// File: hdl/cell_to_vertex_average_3d_core_macros.svh
// Assertion shorthands shared by the RTL.
`ifndef CELL_TO_VERTEX_AVERAGE_3D_CORE_MACROS_SVH
`define CELL_TO_VERTEX_AVERAGE_3D_CORE_MACROS_SVH

// cond implies cons in the same cycle
`define CVA_IMPLIES(lbl, clk_s, rstn_s, cond, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (cond) |-> (cons)) \
		else $error("same-cycle check failed");

// cond implies cons in the next cycle
`define CVA_NEXT(lbl, clk_s, rstn_s, cond, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (cond) |=> (cons)) \
		else $error("next-cycle check failed");

// cond never holds
`define CVA_NEVER(lbl, clk_s, rstn_s, cond) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) \
		else $error("forbidden condition seen");

`endif

// File: hdl/cva_pkg.sv
package cva_pkg;

	localparam int unsigned MAX_X_DEF   = 16;
	localparam int unsigned MAX_Y_DEF   = 16;
	localparam int unsigned MAX_Z_DEF   = 16;

	localparam int unsigned COORD_W     = 5;
	localparam int unsigned SIZE_W      = 5;
	localparam int unsigned VALUE_W     = 32;
	localparam int unsigned SUM_W       = VALUE_W + 3;
	localparam int unsigned CFG_IDX_W   = 2;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = CFG_IDX_W'(2);

	typedef logic [COORD_W-1:0]        coord_t;
	typedef logic [SIZE_W-1:0]         size_t;
	typedef logic signed [VALUE_W-1:0] value_t;

	typedef enum logic [1:0] {
		CMD_WRITE,
		CMD_VERTEX,
		CMD_ERROR
	} cmd_kind_t;

	// one queued command; hi_* alone form the cell address of a write
	typedef struct packed {
		cmd_kind_t kind;
		coord_t    lo_x;
		coord_t    lo_y;
		coord_t    lo_z;
		coord_t    hi_x;
		coord_t    hi_y;
		coord_t    hi_z;
		value_t    value;
	} cva_cmd_t;

endpackage

// File: hdl/cva_ifs.sv
interface cva_req_if import cva_pkg::*; ;
	logic   valid;
	logic   ready;
	logic   operation;
	coord_t coord_x;
	coord_t coord_y;
	coord_t coord_z;
	value_t cell_value;

	modport source(output valid, operation, coord_x, coord_y, coord_z, cell_value,
		input ready);
	modport sink(input valid, operation, coord_x, coord_y, coord_z, cell_value,
		output ready);
endinterface

interface cva_rsp_if import cva_pkg::*; ;
	logic   valid;
	logic   ready;
	value_t vertex_value;
	logic   range_error;

	modport source(output valid, vertex_value, range_error, input ready);
	modport sink(input valid, vertex_value, range_error, output ready);
endinterface

interface cva_cfg_if import cva_pkg::*; ;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	size_t                data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// File: hdl/cva_ram.sv
module cva_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 4096,
	localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] addr,
	input  logic [WIDTH-1:0]  wdata,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else begin
			rdata <= mem[addr];
		end
	end

endmodule

// File: hdl/cva_fifo.sv
module cva_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	function automatic logic [PTR_W-1:0] ptr_next(logic [PTR_W-1:0] p);
		if (p == PTR_W'(DEPTH - 1)) begin
			return '0;
		end
		return p + PTR_W'(1);
	endfunction

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wdata;
		end
	end

endmodule

// File: hdl/cva_front.sv
module cva_front import cva_pkg::*; #(
	parameter int unsigned MAX_X = MAX_X_DEF,
	parameter int unsigned MAX_Y = MAX_Y_DEF,
	parameter int unsigned MAX_Z = MAX_Z_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	cva_req_if.sink      req,
	cva_cfg_if.sink      cfg,
	output logic         push,
	output cva_cmd_t     cmd,
	input  logic         full
);

	size_t size_x_q;
	size_t size_y_q;
	size_t size_z_q;
	size_t nx;
	size_t ny;
	size_t nz;
	logic  bad;

	// zero acts as one, above the build limit saturates
	function automatic size_t eff_size(size_t r, int unsigned maxv);
		if (r == '0) begin
			return SIZE_W'(1);
		end
		if (32'(r) > maxv) begin
			return SIZE_W'(maxv);
		end
		return r;
	endfunction

	// upper cell of a vertex: c clamped to n-1
	function automatic coord_t cell_hi(coord_t c, size_t n);
		if (c >= n) begin
			return n - SIZE_W'(1);
		end
		return c;
	endfunction

	// lower cell of a vertex: c-1 clamped to 0..n-1
	function automatic coord_t cell_lo(coord_t c, size_t n);
		if (c == '0) begin
			return '0;
		end
		if (c - COORD_W'(1) >= n) begin
			return n - SIZE_W'(1);
		end
		return c - COORD_W'(1);
	endfunction

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= SIZE_RESET;
			size_y_q <= SIZE_RESET;
			size_z_q <= SIZE_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_SIZE_X: size_x_q <= cfg.data;
				REG_SIZE_Y: size_y_q <= cfg.data;
				REG_SIZE_Z: size_z_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		nx = eff_size(size_x_q, MAX_X);
		ny = eff_size(size_y_q, MAX_Y);
		nz = eff_size(size_z_q, MAX_Z);
		if (req.operation) begin
			bad = (req.coord_x > nx) || (req.coord_y > ny) || (req.coord_z > nz);
		end else begin
			bad = (req.coord_x >= nx) || (req.coord_y >= ny) || (req.coord_z >= nz);
		end
		if (bad) begin
			cmd.kind = CMD_ERROR;
		end else if (req.operation) begin
			cmd.kind = CMD_VERTEX;
		end else begin
			cmd.kind = CMD_WRITE;
		end
		cmd.lo_x  = cell_lo(req.coord_x, nx);
		cmd.lo_y  = cell_lo(req.coord_y, ny);
		cmd.lo_z  = cell_lo(req.coord_z, nz);
		cmd.hi_x  = cell_hi(req.coord_x, nx);
		cmd.hi_y  = cell_hi(req.coord_y, ny);
		cmd.hi_z  = cell_hi(req.coord_z, nz);
		cmd.value = req.cell_value;
	end

	assign req.ready = !full;
	assign push      = req.valid && !full;

endmodule

// File: hdl/cva_back.sv
`include "cell_to_vertex_average_3d_core_macros.svh"

module cva_back import cva_pkg::*; #(
	parameter int unsigned MAX_X = MAX_X_DEF,
	parameter int unsigned MAX_Y = MAX_Y_DEF,
	parameter int unsigned MAX_Z = MAX_Z_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         empty,
	input  cva_cmd_t     head,
	output logic         pop,
	cva_rsp_if.source    rsp
);

	localparam int unsigned DEPTH  = MAX_X * MAX_Y * MAX_Z;
	localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [ADDR_W-1:0] STRIDE_Y = ADDR_W'(MAX_X);
	localparam logic [ADDR_W-1:0] STRIDE_Z = ADDR_W'(MAX_X * MAX_Y);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DRAIN,
		ST_DONE
	} state_t;

	state_t                   state_q;
	cva_cmd_t                 cmd_q;
	logic [2:0]               step_q;
	logic                     rd_pend_q;
	logic signed [SUM_W-1:0]  acc_q;
	logic                     out_valid_q;
	value_t                   out_value_q;
	logic                     out_err_q;

	coord_t                   cx;
	coord_t                   cy;
	coord_t                   cz;
	logic [ADDR_W-1:0]        ram_addr;
	logic                     ram_we;
	logic [VALUE_W-1:0]       ram_rdata;
	logic signed [SUM_W-1:0]  rd_ext;
	logic                     out_free;
	logic                     out_load;

	// step bit 0/1/2 picks the upper cell in x/y/z
	assign cx = step_q[0] ? cmd_q.hi_x : cmd_q.lo_x;
	assign cy = step_q[1] ? cmd_q.hi_y : cmd_q.lo_y;
	assign cz = step_q[2] ? cmd_q.hi_z : cmd_q.lo_z;
	assign ram_addr = ADDR_W'(cx) + STRIDE_Y * ADDR_W'(cy) + STRIDE_Z * ADDR_W'(cz);

	assign out_free = !out_valid_q || rsp.ready;
	assign out_load = (state_q == ST_DONE) && out_free;
	assign pop      = (state_q == ST_IDLE) && !empty;
	assign ram_we   = (state_q == ST_DONE) && out_free && (cmd_q.kind == CMD_WRITE);
	assign rd_ext   = {{(SUM_W - VALUE_W){ram_rdata[VALUE_W-1]}}, ram_rdata};

	cva_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (cmd_q.value),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			rd_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_pend_q <= (state_q == ST_READ);
			if (rd_pend_q) begin
				acc_q <= acc_q + rd_ext;
			end
			// a new result replaces the one leaving this cycle
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!empty) begin
						cmd_q <= head;
						acc_q <= '0;
						if (head.kind == CMD_VERTEX) begin
							step_q  <= '0;
							state_q <= ST_READ;
						end else begin
							step_q  <= '1;
							state_q <= ST_DONE;
						end
					end
				end
				ST_READ: begin
					step_q <= step_q + 3'd1;
					if (step_q == '1) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_value_q <= (cmd_q.kind == CMD_VERTEX) ?
							acc_q[SUM_W-1:3] : '0;
						out_err_q   <= (cmd_q.kind == CMD_ERROR);
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.vertex_value = out_value_q;
	assign rsp.range_error  = out_err_q;

	`CVA_IMPLIES(a_rd_pend_src, clk, arst_n, rd_pend_q, state_q == ST_READ || state_q == ST_DRAIN)
	`CVA_IMPLIES(a_read_is_vertex, clk, arst_n, state_q == ST_READ, cmd_q.kind == CMD_VERTEX)
	`CVA_NEXT(a_done_loads_out, clk, arst_n, state_q == ST_DONE && out_free, rsp.valid)
	`CVA_NEXT(a_drain_to_done, clk, arst_n, state_q == ST_DRAIN, state_q == ST_DONE)

endmodule

// File: hdl/cell_to_vertex_average_3d_core.sv
// Flow: a vertex beat is read from the queue, then its eight cells are read in turn
//   through the single port of the cell store (ST_READ, ST_DRAIN, ST_DONE); a write
//   or an out-of-range beat goes straight to ST_DONE. The back finishes one command
//   before it takes the next; a stalled output register holds it in ST_DONE.
// Reset: sizes return to 16, queue and output register empty; the cell store
//   is not cleared and holds no defined data until written.
module cell_to_vertex_average_3d_core import cva_pkg::*; #(
	parameter int unsigned MAX_X = MAX_X_DEF,
	parameter int unsigned MAX_Y = MAX_Y_DEF,
	parameter int unsigned MAX_Z = MAX_Z_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	cva_req_if.sink   req,
	cva_rsp_if.source rsp,
	cva_cfg_if.sink   cfg
);

	localparam int unsigned CMD_W = $bits(cva_cmd_t);

	// front -> queue
	logic             push;
	logic             full;
	cva_cmd_t         cmd;

	// queue -> back
	logic             pop;
	logic             empty;
	logic [CMD_W-1:0] q_rdata;
	cva_cmd_t         head;

	// Front: holds the size registers, range-checks each beat and works out
	// the clamped lower/upper cell along every axis. The whole check is one
	// combinational step, so a beat goes into the queue on the cycle it is
	// accepted.
	cva_front #(
		.MAX_X (MAX_X),
		.MAX_Y (MAX_Y),
		.MAX_Z (MAX_Z)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cfg    (cfg),
		.push   (push),
		.cmd    (cmd),
		.full   (full)
	);

	// Short command queue: the front keeps taking beats while the back is
	// busy reading cells or waiting on a stalled output.
	cva_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cmd),
		.full   (full),
		.pop    (pop),
		.rdata  (q_rdata),
		.empty  (empty)
	);

	assign head = cva_cmd_t'(q_rdata);

	// Back: owns the cell store. A vertex steps through its eight cells, one
	// read a cycle, and sums them at 35 bits; the arithmetic shift by three
	// is a plain bit slice of the sum. A write touches the store once, when
	// its result goes into the output register.
	cva_back #(
		.MAX_X (MAX_X),
		.MAX_Y (MAX_Y),
		.MAX_Z (MAX_Z)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.head   (head),
		.pop    (pop),
		.rsp    (rsp)
	);

endmodule
